// ===== design/bpc_pkg.sv =====
// bpc_pkg: shared types and constants for the button press classifier
// event codes, register indexes and register reset values; no dependencies
`default_nettype none

package bpc_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CntW-1:0] cnt_t;

  // event codes carried on event_res
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_SHORT  = 3'd3,
    EV_LONG   = 3'd4
  } event_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_DOUBLE   = 2'd3
  } cfg_idx_e;

  // register reset values
  localparam cnt_t DebounceRst = 16'd20;
  localparam cnt_t ShortRst    = 16'd500;
  localparam cnt_t LongRst     = 16'd2000;
  localparam cnt_t DoubleRst   = 16'd300;

  localparam cnt_t CntMax = '1;

  // counter increment that sticks at full scale
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CntMax) ? v : v + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

// ===== design/button_press_classifier_core.sv =====
// button_press_classifier_core: single, double, short-hold and long-hold detection
// for one active-low button sampled once per tick word; depends on bpc_pkg
//
// result: registered, appearing in the cycle after its tick word is accepted
// throughput: one tick word per cycle; the output register stalls the input only
//   while a result is held back by out_stall_i
// reset: asynchronous active low; counters and flags clear, registers take defaults
`default_nettype none

module button_press_classifier_core import bpc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CntW-1:0]    cfg_data_i,
  // tick input
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               pin_level_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              event_res_o,
  output logic [CntW-1:0]         held_time_o
);

  // configuration registers
  cnt_t debounce_q, short_q, long_q, double_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      short_q    <= ShortRst;
      long_q     <= LongRst;
      double_q   <= DoubleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_SHORT:    short_q    <= cfg_data_i;
        CFG_LONG:     long_q     <= cfg_data_i;
        CFG_DOUBLE:   double_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // handshake: take a word unless a result is held back
  logic in_acc, out_valid_q;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // press and click state
  logic   down_q, down_d, pend_q, pend_d;
  cnt_t   press_q, press_d, since_q, since_d, last_q, last_d;
  event_e ev_d, ev_q;

  // per-tick update
  always_comb begin
    cnt_t since_inc;
    logic accepted;
    since_inc = pend_q ? sat_inc(since_q) : since_q;
    accepted  = 1'b0;
    down_d    = down_q;
    press_d   = press_q;
    pend_d    = pend_q;
    since_d   = since_inc;
    last_d    = last_q;
    ev_d      = EV_NONE;
    if (!pin_level_i) begin
      down_d  = 1'b1;
      press_d = sat_inc(press_q);
    end else begin
      down_d  = 1'b0;
      press_d = '0;
      // release of an accepted press
      if (down_q && (press_q > debounce_q)) begin
        accepted = 1'b1;
        last_d   = press_q;
        since_d  = '0;
        priority if (press_q >= long_q) begin
          pend_d = 1'b0;
          ev_d   = EV_LONG;
        end else if (press_q >= short_q) begin
          pend_d = 1'b0;
          ev_d   = EV_SHORT;
        end else if (pend_q && (since_inc < double_q)) begin
          pend_d = 1'b0;
          ev_d   = EV_DOUBLE;
        end else begin
          pend_d = 1'b1;
          ev_d   = EV_NONE;
        end
      end
      // pending click timed out
      if (!accepted && pend_q && (since_inc > double_q)) begin
        pend_d  = 1'b0;
        since_d = '0;
        ev_d    = EV_SINGLE;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= 1'b0;
      press_q <= '0;
      pend_q  <= 1'b0;
      since_q <= '0;
      last_q  <= '0;
    end else if (in_acc) begin
      down_q  <= down_d;
      press_q <= press_d;
      pend_q  <= pend_d;
      since_q <= since_d;
      last_q  <= last_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_q <= ev_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign held_time_o = last_q;

  // checks
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word gave no result");

  a_single_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_res_o == EV_SINGLE)) |-> !pend_q)
    else $error("single press left click pending");

  a_down_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    down_q |-> (press_q != '0))
    else $error("button down with zero press count");

  a_held_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((event_res_o == EV_LONG) || (event_res_o == EV_SHORT)))
      |-> (!pend_q && (since_q == '0)))
    else $error("hold event left click state");

endmodule

`default_nettype wire
